// ----- rtl/jsfe_pkg.sv -----
// Shared types and constants of the JSON string field extractor.
// No dependencies; imported by every module under rtl/.
`default_nettype none

package jsfe_pkg;

	localparam int MAX_KEY_CHARS = 8;
	localparam int WIN_DEPTH     = MAX_KEY_CHARS + 1;
	localparam int KEY_BITS      = 8 * MAX_KEY_CHARS;
	localparam int CFG_BITS      = KEY_BITS;
	localparam int LEN_BITS      = 4;
	localparam int OBUF_DEPTH    = 2;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	// configuration register indexes
	localparam logic REG_KEY_TEXT   = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		ST_RUNNING = 2'd0,
		ST_FOUND   = 2'd1,
		ST_FAILED  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_SEARCH = 4'b0001,
		PH_COLON  = 4'b0010,
		PH_SPACE  = 4'b0100,
		PH_VALUE  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       body_end;
	} in_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       finished;
	} out_t;

	// one entry of the sliding match window
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} win_link_t;

	// window control from the parser
	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/json_string_field_extractor.sv -----
// Top level of the JSON string field extractor: config registers, match
// window of jsfe_cell, jsfe_ctrl sequencer, result buffer. Uses jsfe_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   item     | item_valid / item_stall| item   (data_byte, body_end)
//   result   | result_valid / _stall  | result (value_byte, byte_valid,
//            |                        |         status, finished)
//   config   | cfg_we                 | cfg_index, cfg_data
//
// One body byte per cycle unless stalled; results leave via the buffer.
// The match window is a row of nine byte cells shifting per accepted byte
// in the key search; all nine compares plus one AND tree set the cycle.
// Reset leaves the key empty and the block searching for a new body.
// item_stall rises only while both result buffer entries are occupied.
`default_nettype none

module json_string_field_extractor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire jsfe_pkg::in_t                 item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output jsfe_pkg::out_t                     result,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [jsfe_pkg::CFG_BITS-1:0] cfg_data
);
	import jsfe_pkg::*;

	localparam int PTR_BITS = $clog2(OBUF_DEPTH);
	localparam int CNT_BITS = $clog2(OBUF_DEPTH + 1);

	logic [KEY_BITS-1:0] key_text_q;
	logic [LEN_BITS-1:0] key_length_q;
	logic [LEN_BITS-1:0] key_len;

	logic       accept;
	logic       key_hit;
	logic       emit;
	out_t       res_new;
	win_ctl_t   win_ctl;
	win_link_t  link [WIN_DEPTH+1];
	logic [WIN_DEPTH-1:0] cell_ok;

	out_t                buf_q [OBUF_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q   <= '0;
			key_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_TEXT:   key_text_q   <= cfg_data;
				REG_KEY_LENGTH: key_length_q <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign key_len = (key_length_q > LEN_BITS'(MAX_KEY_CHARS))
		? LEN_BITS'(MAX_KEY_CHARS) : key_length_q;

	assign accept = item_valid && !item_stall;

	assign link[0] = '{valid: 1'b1, data: item.data_byte};

	for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
		jsfe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (LEN_BITS'(j)),
			.key_len  (key_len),
			.key_text (key_text_q),
			.ctl      (win_ctl),
			.prev     (link[j]),
			.cur      (link[j+1]),
			.ok       (cell_ok[j])
		);
	end

	assign key_hit = (item.data_byte == CH_QUOTE) && (&cell_ok);

	jsfe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.key_hit (key_hit),
		.win_ctl (win_ctl),
		.emit    (emit),
		.result  (res_new)
	);

	// two-entry result buffer decouples the sides
	assign pop          = result_valid && !result_stall;
	assign result_valid = (cnt_q != '0);
	assign item_stall   = (cnt_q == CNT_BITS'(OBUF_DEPTH));
	assign result       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			buf_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (emit) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			unique case ({emit, pop})
				2'b10:   cnt_q <= cnt_q + CNT_BITS'(1);
				2'b01:   cnt_q <= cnt_q - CNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(OBUF_DEPTH))
		else $error("result buffer overflow");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> cnt_q != CNT_BITS'(OBUF_DEPTH))
		else $error("result written into full buffer");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("buffer pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsfe_cell.sv -----
// One cell of the key match window: holds one byte, shifts it on to its
// neighbor, and compares it against its key character or the opening quote. Uses jsfe_pkg.
`default_nettype none

module jsfe_cell (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [jsfe_pkg::LEN_BITS-1:0]   cell_idx,
	input  wire logic [jsfe_pkg::LEN_BITS-1:0]   key_len,
	input  wire logic [jsfe_pkg::KEY_BITS-1:0]   key_text,
	input  wire jsfe_pkg::win_ctl_t              ctl,
	input  wire jsfe_pkg::win_link_t             prev,
	output jsfe_pkg::win_link_t                  cur,
	output logic                                 ok
);
	import jsfe_pkg::*;

	logic                valid_q;
	logic [7:0]          data_q;
	logic [2:0]          key_pos;
	logic [7:0]          expected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= prev.data;
		end
	end

	// cell j sees key char len-1-j, and the opening quote at j == len
	always_comb begin
		key_pos  = 3'(key_len - cell_idx - LEN_BITS'(1));
		expected = (cell_idx < key_len)
			? key_text[{key_pos, 3'b000} +: 8] : CH_QUOTE;
		ok       = (cell_idx > key_len) || (valid_q && (data_q == expected));
	end

	assign cur = '{valid: valid_q, data: data_q};

endmodule

`default_nettype wire

// ----- rtl/jsfe_ctrl.sv -----
// Phase sequencer of the extractor: key match result in, value decode,
// completion and failure results out. Uses jsfe_pkg.
`default_nettype none

module jsfe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire jsfe_pkg::in_t item,
	input  wire logic          key_hit,
	output jsfe_pkg::win_ctl_t win_ctl,
	output logic               emit,
	output jsfe_pkg::out_t     result
);
	import jsfe_pkg::*;

	phase_t phase_q, phase_d;
	logic   esc_q, esc_d;
	logic   done_q, done_d;
	logic   push;
	logic [7:0] c;

	assign c = item.data_byte;

	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		done_d  = done_q;
		emit    = 1'b0;
		push    = 1'b0;
		result  = '{value_byte: 8'h00, byte_valid: 1'b0,
			status: ST_RUNNING, finished: 1'b0};

		if (!done_q) begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (key_hit) begin
						phase_d = PH_COLON;
					end else begin
						push = 1'b1;
					end
				end
				PH_COLON: begin
					if (c == CH_COLON) begin
						phase_d = PH_SPACE;
					end
				end
				PH_SPACE: begin
					if (c == CH_QUOTE) begin
						phase_d = PH_VALUE;
					end else if (!(c == CH_SPACE || c == CH_TAB ||
							c == CH_CR || c == CH_LF)) begin
						emit            = 1'b1;
						result.status   = ST_FAILED;
						result.finished = 1'b1;
						done_d          = 1'b1;
					end
				end
				PH_VALUE: begin
					if (esc_q) begin
						esc_d             = 1'b0;
						emit              = 1'b1;
						result.byte_valid = 1'b1;
						priority if (c == CH_N) begin
							result.value_byte = CH_LF;
						end else if (c == CH_R) begin
							result.value_byte = CH_CR;
						end else if (c == CH_T) begin
							result.value_byte = CH_TAB;
						end else begin
							result.value_byte = c;
						end
					end else if (c == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == CH_QUOTE) begin
						emit            = 1'b1;
						result.status   = ST_FOUND;
						result.finished = 1'b1;
						done_d          = 1'b1;
					end else begin
						emit              = 1'b1;
						result.byte_valid = 1'b1;
						result.value_byte = c;
					end
				end
				default: begin
					phase_d = PH_SEARCH;
				end
			endcase
			// body ran out before the value closed
			if (item.body_end && !done_d) begin
				emit   = 1'b1;
				result = '{value_byte: 8'h00, byte_valid: 1'b0,
					status: ST_FAILED, finished: 1'b1};
			end
		end

		if (item.body_end) begin
			phase_d = PH_SEARCH;
			esc_d   = 1'b0;
			done_d  = 1'b0;
		end

		emit          = emit && accept;
		win_ctl.shift = push && accept;
		win_ctl.clear = item.body_end && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			esc_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			done_q  <= done_d;
		end
	end

`ifndef SYNTHESIS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && done_q |-> !emit)
		else $error("result produced after extraction finished");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.body_end |=> phase_q == PH_SEARCH && !done_q && !esc_q)
		else $error("body end did not re-arm");
	a_esc_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == PH_VALUE)
		else $error("escape pending outside value");
	a_push_search: assert property (@(posedge clk) disable iff (!arst_n)
		win_ctl.shift |-> phase_q == PH_SEARCH && !done_q)
		else $error("window shifted outside key search");
`endif

endmodule

`default_nettype wire
